@@ rtl/imu_cal_pkg.sv @@
`default_nettype none

package imu_cal_pkg;

    localparam int RAW_W = 16;
    localparam int MAG_W = 16;
    localparam int MUL_W = 10;
    localparam int PROD_W = MAG_W + MUL_W;
    localparam int TW = 31;
    localparam int RECIP_W = 32;
    localparam int VAL_W = 27;
    localparam int SUM_W = 37;
    localparam int CNT_W = 10;
    localparam int QW = 28;

    localparam int DEF_MAX_SAMPLES = 1000;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [CNT_W-1:0] FALLBACK_SAMPLES = 10'd100;

    // counts scaled by 981/100 resp. 250 over 16384
    localparam logic [MUL_W-1:0] ACCEL_MUL = 10'd981;
    localparam logic [MUL_W-1:0] GYRO_MUL = 10'd250;

    // gyro divisor is 2^14, accel divisor is 25 * 2^16
    localparam int GYRO_SHIFT = 14;
    localparam int ACCEL_SHIFT = 16;
    localparam logic [TW-1:0] GYRO_HALF = 31'd8192;
    localparam logic [TW-1:0] ACCEL_HALF = 31'd819200;
    // past these the quotient saturates for either sign
    localparam logic [TW-1:0] GYRO_LIM = 31'd67108865;
    localparam logic [TW-1:0] ACCEL_LIM = 31'd1677721625;
    // ceil(2^36 / 25), exact divide by 25 for dividends below 2^31
    localparam logic [RECIP_W-1:0] ACCEL_RECIP = 32'd2748779070;
    localparam int RECIP_SHIFT = 36;

    localparam logic KIND_ACCEL = 1'b0;
    localparam logic KIND_GYRO = 1'b1;
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_CAL = 1'b1;

    localparam logic REG_CAL_SAMPLES = 1'b0;

    typedef struct packed {
        logic             mul;
        logic             scale_load;
        logic             recip;
        logic             mean_load;
        logic             step;
        logic             scale_fin;
        logic             apply;
        logic             accumulate;
        logic             clear_sum;
        logic             mean_fin;
        logic             kind;
        logic [CNT_W-1:0] count;
    } lane_cmd_t;

    typedef struct packed {
        logic load;
        logic done;
        logic kind;
    } out_ctl_t;

endpackage

`default_nettype wire

@@ rtl/imu_cal_lane.sv @@
`default_nettype none

module imu_cal_lane
    import imu_cal_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [RAW_W-1:0]        raw,
    input  wire logic                    raw_kind,
    input  wire lane_cmd_t               cmd,
    output logic signed [VAL_W-1:0]      value
);

    localparam int NW = PROD_W + FRAC_BITS + 1;
    localparam int RW = CNT_W + QW + 1;
    localparam int PW = TW + RECIP_W;

    localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (VAL_W - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (VAL_W - 1));

    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    logic [TW-1:0]           t_reg;
    logic [RW-1:0]           rem_reg;
    logic [RW-1:0]           dsh_reg;
    logic [QW-1:0]           q_reg;
    logic signed [VAL_W-1:0] scaled_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [VAL_W-1:0] accel_off_reg;
    logic signed [VAL_W-1:0] gyro_off_reg;

    logic [MAG_W-1:0]        raw_mag;
    logic [SUM_W-1:0]        sum_mag;
    logic [NW-1:0]           scale_num;
    logic [NW-1:0]           scale_t;
    logic [NW-1:0]           scale_lim;
    logic [PW-1:0]           recip_prod;
    logic [RW-1:0]           ld_den;
    logic [RW-1:0]           ld_num;
    logic [RW-1:0]           ld_lim;
    logic                    q_bit;
    logic signed [VAL_W-1:0] q_fix;
    logic signed [VAL_W-1:0] off_sel;
    logic signed [VAL_W:0]   diff;
    logic signed [VAL_W-1:0] diff_sat;
    logic signed [SUM_W-1:0] sum_base;

    function automatic logic signed [VAL_W-1:0] sat_quot(input logic neg,
                                                          input logic [QW-1:0] q);
        logic [QW-1:0] nq;
        nq = ~q + 1'b1;
        if (!neg)
        begin
            sat_quot = (q > POS_LIM) ? POS_LIM[VAL_W-1:0] : q[VAL_W-1:0];
        end
        else
        begin
            sat_quot = (q > NEG_LIM) ? NEG_LIM[VAL_W-1:0] : nq[VAL_W-1:0];
        end
    endfunction

    assign raw_mag = raw[RAW_W-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // round half up on the magnitude and drop the power-of-two part of the divisor
    always_comb
    begin
        if (cmd.kind == KIND_GYRO)
        begin
            scale_num = (NW'(prod_reg) << FRAC_BITS) + NW'(GYRO_HALF);
            scale_t   = scale_num >> GYRO_SHIFT;
            scale_lim = NW'(GYRO_LIM);
        end
        else
        begin
            scale_num = (NW'(prod_reg) << FRAC_BITS) + NW'(ACCEL_HALF);
            scale_t   = scale_num >> ACCEL_SHIFT;
            scale_lim = NW'(ACCEL_LIM);
        end
    end

    // remaining accel divide by 25 through the reciprocal
    assign recip_prod = PW'(t_reg) * PW'(ACCEL_RECIP);

    // mean divider loader: round by adding half the count,
    // clamp so the quotient fits QW bits (larger values saturate anyway)
    always_comb
    begin
        ld_den = RW'(cmd.count);
        ld_num = RW'(sum_mag) + (ld_den >> 1);
        ld_lim = (ld_den << QW) - 1'b1;
    end

    assign q_bit = (rem_reg >= dsh_reg);
    assign q_fix = sat_quot(neg_reg, q_reg);
    assign off_sel = (cmd.kind == KIND_GYRO) ? gyro_off_reg : accel_off_reg;
    assign diff = {scaled_reg[VAL_W-1], scaled_reg} - {off_sel[VAL_W-1], off_sel};
    assign sum_base = cmd.clear_sum ? '0 : sum_reg;

    always_comb
    begin
        if (diff[VAL_W] != diff[VAL_W-1])
        begin
            diff_sat = diff[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            diff_sat = diff[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(raw_mag) *
                        PROD_W'((raw_kind == KIND_GYRO) ? GYRO_MUL : ACCEL_MUL);
            neg_reg  <= raw[RAW_W-1];
        end
        if (cmd.mean_load)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.scale_load)
        begin
            t_reg <= (scale_t > scale_lim) ? scale_lim[TW-1:0] : scale_t[TW-1:0];
        end
        if (cmd.recip)
        begin
            q_reg <= (cmd.kind == KIND_GYRO) ? QW'(t_reg) : QW'(recip_prod >> RECIP_SHIFT);
        end
        if (cmd.mean_load)
        begin
            rem_reg <= (ld_num > ld_lim) ? ld_lim : ld_num;
            dsh_reg <= ld_den << (QW - 1);
        end
        else if (cmd.step)
        begin
            if (q_bit)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QW-2:0], q_bit};
        end
        if (cmd.scale_fin)
        begin
            scaled_reg <= q_fix;
        end
        if (cmd.apply)
        begin
            val_reg <= diff_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            accel_off_reg <= '0;
            gyro_off_reg  <= '0;
        end
        else
        begin
            if (cmd.apply && cmd.accumulate)
            begin
                sum_reg <= sum_base +
                           {{(SUM_W-VAL_W){scaled_reg[VAL_W-1]}}, scaled_reg};
            end
            else if (cmd.mean_fin)
            begin
                sum_reg <= '0;
            end
            if (cmd.mean_fin)
            begin
                if (cmd.kind == KIND_GYRO)
                begin
                    gyro_off_reg <= q_fix;
                end
                else
                begin
                    accel_off_reg <= q_fix;
                end
            end
        end
    end

    assign value = val_reg;

endmodule

`default_nettype wire

@@ rtl/imu_cal_ctrl.sv @@
`default_nettype none

module imu_cal_ctrl
    import imu_cal_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             req_type,
    input  wire logic             sensor_kind,
    input  wire logic [CNT_W-1:0] cal_samples,
    input  wire logic             out_free,
    output logic                  in_ready,
    output lane_cmd_t             cmd,
    output out_ctl_t              octl
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_RECIP = 4'd2;
    localparam logic [3:0] ST_FIN   = 4'd3;
    localparam logic [3:0] ST_APPLY = 4'd4;
    localparam logic [3:0] ST_MLOAD = 4'd5;
    localparam logic [3:0] ST_MSTEP = 4'd6;
    localparam logic [3:0] ST_MFIN  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam int IT_W = $clog2(QW);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(QW - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic [3:0]       state_reg, state_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic             req_reg, req_next;
    logic             kind_reg, kind_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] samples_reg, samples_next;
    logic             run_kind_reg, run_kind_next;

    logic             in_fire;
    logic [CNT_W-1:0] target;
    logic             restart;
    logic [CNT_W-1:0] cnt_inc;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign target = (cal_samples == '0 || cal_samples > MAX_CNT) ? FALLBACK_SAMPLES
                                                                  : cal_samples;
    // kind change during a run drops what was summed so far
    assign restart = (samples_reg != '0) && (kind_reg != run_kind_reg);
    assign cnt_inc = (restart ? '0 : samples_reg) + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        it_next       = it_reg;
        req_next      = req_reg;
        kind_next     = kind_reg;
        done_next     = done_reg;
        samples_next  = samples_reg;
        run_kind_next = run_kind_reg;
        cmd           = '0;
        cmd.kind      = kind_reg;
        cmd.count     = samples_reg;
        octl.load     = 1'b0;
        octl.done     = done_reg;
        octl.kind     = kind_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.mul    = 1'b1;
                    req_next   = req_type;
                    kind_next  = sensor_kind;
                    done_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.scale_load = 1'b1;
                state_next     = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.scale_fin = 1'b1;
                state_next    = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_OUT;
                if (req_reg == REQ_CAL)
                begin
                    cmd.accumulate = 1'b1;
                    cmd.clear_sum  = restart;
                    run_kind_next  = kind_reg;
                    samples_next   = cnt_inc;
                    if (cnt_inc >= target)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_MLOAD;
                    end
                end
            end
            ST_MLOAD:
            begin
                cmd.mean_load = 1'b1;
                it_next       = '0;
                state_next    = ST_MSTEP;
            end
            ST_MSTEP:
            begin
                cmd.step = 1'b1;
                it_next  = it_reg + 1'b1;
                if (it_reg == IT_LAST)
                begin
                    state_next = ST_MFIN;
                end
            end
            ST_MFIN:
            begin
                cmd.mean_fin = 1'b1;
                samples_next = '0;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    octl.load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            it_reg       <= '0;
            req_reg      <= 1'b0;
            kind_reg     <= 1'b0;
            done_reg     <= 1'b0;
            samples_reg  <= '0;
            run_kind_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            it_reg       <= it_next;
            req_reg      <= req_next;
            kind_reg     <= kind_next;
            done_reg     <= done_next;
            samples_reg  <= samples_next;
            run_kind_reg <= run_kind_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/imu_sample_scale_offset_calibrate_unit.sv @@
`default_nettype none

// Scales three-axis raw IMU counts into signed Q10.16 (accelerometer by
// 9.81/16384, gyroscope by 250/16384, rounded half away from zero), removes
// the stored per-sensor offset, and on calibration samples averages the
// scaled values into a new offset once cal_samples of them are in (0 or
// anything above MAX_SAMPLES counts as 100). The X, Y and Z axes run in
// three lanes side by side; each scales by a multiply, a shift and, for the
// accelerometer, a reciprocal multiply, and has its own 28-step shift-subtract
// divider for the mean; the output register gathers the lanes into one
// result. The result is offered after the load, reciprocal, finish and apply
// states, and when the item completes a calibration also after the mean
// divider's load, step and finish states; the output state then waits until
// the output register is free. The next item is accepted once the result is
// in the output register. One item is worked on at a time; the next is
// accepted while the previous result is still waiting in the output register.
// cal_samples sits at byte address 0 of the APB port.
module imu_sample_scale_offset_calibrate_unit
    import imu_cal_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                req_type,
    input  wire logic                sensor_kind,
    input  wire logic [7:0]          x_high_byte,
    input  wire logic [7:0]          x_low_byte,
    input  wire logic [7:0]          y_high_byte,
    input  wire logic [7:0]          y_low_byte,
    input  wire logic [7:0]          z_high_byte,
    input  wire logic [7:0]          z_low_byte,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     kind_echo,
    output logic signed [VAL_W-1:0]  x_value,
    output logic signed [VAL_W-1:0]  y_value,
    output logic signed [VAL_W-1:0]  z_value,
    output logic                     calibration_done
);

    logic [CNT_W-1:0]        cal_samples_reg;
    logic                    out_valid_reg;
    logic                    kind_reg;
    logic                    done_reg;
    logic signed [VAL_W-1:0] x_reg;
    logic signed [VAL_W-1:0] y_reg;
    logic signed [VAL_W-1:0] z_reg;

    logic [RAW_W-1:0]        raw [3];
    logic signed [VAL_W-1:0] lane_val [3];
    lane_cmd_t               cmd;
    out_ctl_t                octl;
    logic                    out_free;
    logic                    cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAL_SAMPLES);
    assign prdata = (paddr[2] == REG_CAL_SAMPLES) ? 32'(cal_samples_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= FALLBACK_SAMPLES;
        end
        else if (cfg_write)
        begin
            cal_samples_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign raw[0] = {x_high_byte, x_low_byte};
    assign raw[1] = {y_high_byte, y_low_byte};
    assign raw[2] = {z_high_byte, z_low_byte};

    assign out_free = !out_valid_reg || out_ready;

    imu_cal_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .req_type    (req_type),
        .sensor_kind (sensor_kind),
        .cal_samples (cal_samples_reg),
        .out_free    (out_free),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .octl        (octl)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        imu_cal_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .raw      (raw[i]),
            .raw_kind (sensor_kind),
            .cmd      (cmd),
            .value    (lane_val[i])
        );
    end

    // merge the three lanes into one result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (octl.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (octl.load)
        begin
            kind_reg <= octl.kind;
            done_reg <= octl.done;
            x_reg    <= lane_val[0];
            y_reg    <= lane_val[1];
            z_reg    <= lane_val[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind_echo = kind_reg;
    assign calibration_done = done_reg;
    assign x_value = x_reg;
    assign y_value = y_reg;
    assign z_value = z_reg;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;
    import imu_cal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int END_WAIT = 70;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 200;
    localparam logic [2:0] CAL_SAMPLES_ADDR = 3'(4 * REG_CAL_SAMPLES);
    localparam longint VAL_HI = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint VAL_LO = -(longint'(1) <<< (VAL_W - 1));
    localparam longint FRAC_ONE = longint'(1) <<< DEF_FRAC_BITS;

    typedef struct packed {
        logic            req;
        logic            kind;
        logic [2:0][7:0] hi;
        logic [2:0][7:0] lo;
    } sample_t;

    typedef struct packed {
        logic                  kind;
        logic [2:0][VAL_W-1:0] val;
        logic                  done;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       req_type = 1'b0;
    logic       sensor_kind = 1'b0;
    logic [7:0] x_high_byte = '0;
    logic [7:0] x_low_byte = '0;
    logic [7:0] y_high_byte = '0;
    logic [7:0] y_low_byte = '0;
    logic [7:0] z_high_byte = '0;
    logic [7:0] z_low_byte = '0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    kind_echo;
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;
    logic signed [VAL_W-1:0] z_value;
    logic                    calibration_done;

    // predictor state
    longint sensor_offset [2][3] = '{default: 0};
    longint run_sum [3] = '{default: 0};
    int     run_count = 0;
    logic   run_kind = KIND_ACCEL;
    int     cal_target_reg = int'(FALLBACK_SAMPLES);

    reading_t pending_readings [$];
    int       mismatches = 0;
    logic     tx_idle_on = 1'b1;
    logic     rx_idle_on = 1'b1;
    logic     long_hold_pending = 1'b0;

    always #5 clk = ~clk;

    imu_sample_scale_offset_calibrate_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .sensor_kind      (sensor_kind),
        .x_high_byte      (x_high_byte),
        .x_low_byte       (x_low_byte),
        .y_high_byte      (y_high_byte),
        .y_low_byte       (y_low_byte),
        .z_high_byte      (z_high_byte),
        .z_low_byte       (z_low_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind_echo        (kind_echo),
        .x_value          (x_value),
        .y_value          (y_value),
        .z_value          (z_value),
        .calibration_done (calibration_done)
    );

    function automatic longint clip_val(longint v);
        if (v > VAL_HI)
            return VAL_HI;
        if (v < VAL_LO)
            return VAL_LO;
        return v;
    endfunction

    // round to nearest, ties away from zero; den > 0
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic reading_t predict_reading(sample_t s);
        reading_t r;
        longint scaled [3];
        logic signed [15:0] raw;
        int target;
        int i;
        r = '0;
        r.kind = s.kind;
        for (i = 0; i < 3; i++)
        begin
            raw = {s.hi[i], s.lo[i]};
            if (s.kind == KIND_ACCEL)
                scaled[i] = clip_val(round_div(longint'(raw) * 981 * FRAC_ONE, 100 * 16384));
            else
                scaled[i] = clip_val(round_div(longint'(raw) * 250 * FRAC_ONE, 16384));
            r.val[i] = VAL_W'(clip_val(scaled[i] - sensor_offset[s.kind][i]));
        end
        if (s.req == REQ_CAL)
        begin
            target = cal_target_reg;
            if (target < 1 || target > DEF_MAX_SAMPLES)
                target = int'(FALLBACK_SAMPLES);
            // a different sensor kind restarts the run
            if (run_count > 0 && s.kind != run_kind)
            begin
                run_count = 0;
                run_sum = '{default: 0};
            end
            run_kind = s.kind;
            for (i = 0; i < 3; i++)
                run_sum[i] += scaled[i];
            run_count++;
            if (run_count >= target)
            begin
                for (i = 0; i < 3; i++)
                begin
                    sensor_offset[s.kind][i] = clip_val(round_div(run_sum[i], run_count));
                    run_sum[i] = 0;
                end
                run_count = 0;
                r.done = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endfunction

    function automatic void check_reading(reading_t got);
        reading_t want;
        if (pending_readings.size() == 0)
        begin
            note_mismatch($sformatf("unexpected reading kind %0d x %0d y %0d z %0d done %0d",
                got.kind, $signed(got.val[0]), $signed(got.val[1]), $signed(got.val[2]),
                got.done));
            return;
        end
        want = pending_readings.pop_front();
        if (got.kind !== want.kind || got.val[0] !== want.val[0] || got.val[1] !== want.val[1]
            || got.val[2] !== want.val[2] || got.done !== want.done)
            note_mismatch($sformatf(
                "expected kind %0d x %0d y %0d z %0d done %0d, got kind %0d x %0d y %0d z %0d done %0d",
                want.kind, $signed(want.val[0]), $signed(want.val[1]), $signed(want.val[2]),
                want.done, got.kind, $signed(got.val[0]), $signed(got.val[1]),
                $signed(got.val[2]), got.done));
    endfunction

    function automatic sample_t make_sample(logic req, logic kind, logic [15:0] x,
                                            logic [15:0] y, logic [15:0] z);
        sample_t s;
        s.req = req;
        s.kind = kind;
        {s.hi[0], s.lo[0]} = x;
        {s.hi[1], s.lo[1]} = y;
        {s.hi[2], s.lo[2]} = z;
        return s;
    endfunction

    function automatic logic [15:0] random_count();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // called right after a rising edge; returns at the edge that accepts the transaction
    task automatic send_sample(input sample_t s);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= s.req;
        sensor_kind <= s.kind;
        x_high_byte <= s.hi[0];
        x_low_byte <= s.lo[0];
        y_high_byte <= s.hi[1];
        y_low_byte <= s.lo[1];
        z_high_byte <= s.hi[2];
        z_low_byte <= s.lo[2];
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        pending_readings.push_back(predict_reading(s));
    endtask

    task automatic drain_readings();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_readings.size() != 0);
    endtask

    // write then read back; only while the block is idle
    task automatic write_cal_samples(input logic [CNT_W-1:0] value);
        drain_readings();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAL_SAMPLES_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        cal_target_reg = int'(value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        if (prdata !== 32'(value))
            note_mismatch($sformatf("cal_samples read back %0d, expected %0d", prdata, value));
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_raw_extremes();
        send_sample(make_sample(REQ_MEASURE, KIND_ACCEL, 16'h7FFF, 16'h8000, 16'h0000));
        send_sample(make_sample(REQ_MEASURE, KIND_ACCEL, 16'hFFFF, 16'h0001, 16'h8000));
        send_sample(make_sample(REQ_MEASURE, KIND_GYRO, 16'h7FFF, 16'h8000, 16'h0000));
        send_sample(make_sample(REQ_MEASURE, KIND_GYRO, 16'hFFFF, 16'h0001, 16'h7FFF));
    endtask

    task automatic test_single_sample_calibration();
        write_cal_samples(10'd1);
        send_sample(make_sample(REQ_CAL, KIND_ACCEL, 16'h1234, 16'hFF00, 16'h4000));
        send_sample(make_sample(REQ_MEASURE, KIND_ACCEL, 16'h1234, 16'h0000, 16'hC000));
        // large negative gyro offset pushes the next correction near the top of range
        send_sample(make_sample(REQ_CAL, KIND_GYRO, 16'h8000, 16'h8000, 16'h7FFF));
        send_sample(make_sample(REQ_MEASURE, KIND_GYRO, 16'h7FFF, 16'h7FFF, 16'h8000));
    endtask

    task automatic test_kind_switch();
        write_cal_samples(10'd3);
        send_sample(make_sample(REQ_CAL, KIND_ACCEL, 16'h0100, 16'h0200, 16'h0300));
        send_sample(make_sample(REQ_CAL, KIND_ACCEL, 16'h0101, 16'h0202, 16'h0303));
        send_sample(make_sample(REQ_MEASURE, KIND_GYRO, 16'h0010, 16'h0020, 16'h0030));
        send_sample(make_sample(REQ_CAL, KIND_GYRO, 16'hF000, 16'h0F00, 16'h00F0));
        send_sample(make_sample(REQ_CAL, KIND_GYRO, 16'hF001, 16'h0F01, 16'h00F1));
        send_sample(make_sample(REQ_CAL, KIND_GYRO, 16'hF003, 16'h0F02, 16'h00F2));
        send_sample(make_sample(REQ_MEASURE, KIND_GYRO, 16'hF000, 16'h0F00, 16'h00F0));
    endtask

    task automatic test_target_lowered();
        int i;
        write_cal_samples(10'd1000);
        for (i = 0; i < 5; i++)
            send_sample(make_sample(REQ_CAL, KIND_ACCEL, random_count(), random_count(),
                                    random_count()));
        write_cal_samples(10'd2);
        send_sample(make_sample(REQ_CAL, KIND_ACCEL, 16'h0FFF, 16'hF001, 16'h0000));
        send_sample(make_sample(REQ_MEASURE, KIND_ACCEL, 16'h0FFF, 16'hF001, 16'h0000));
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        logic [CNT_W-1:0] target;
        logic cal_kind;
        logic req;
        logic kind;
        cal_kind = KIND_ACCEL;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                2: target = 10'd0;
                6: target = 10'd1023;
                5: target = 10'd1001;
                default: target = CNT_W'((phase % 2 == 0) ? $urandom_range(1, 8)
                                                           : $urandom_range(1, 40));
            endcase
            write_cal_samples(target);
            tx_idle_on = (phase % 3 != 1);
            rx_idle_on = (phase % 3 != 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // receiver stops for a long while, sender keeps offering
                if (phase == 1 && n == 100)
                    long_hold_pending = 1'b1;
                req = ($urandom_range(0, 3) != 0) ? REQ_CAL : REQ_MEASURE;
                if (req == REQ_CAL)
                begin
                    if ($urandom_range(0, 15) == 0)
                        cal_kind = ~cal_kind;
                    kind = cal_kind;
                end
                else
                    kind = 1'($urandom);
                send_sample(make_sample(req, kind, random_count(), random_count(),
                                        random_count()));
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_raw_extremes();
        test_single_sample_calibration();
        test_kind_switch();
        test_target_lowered();
        test_random_traffic();
        drain_readings();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : reading_sink
        int stall;
        reading_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            // transaction completes at the next rising edge
            got.kind = kind_echo;
            got.val[0] = x_value;
            got.val[1] = y_value;
            got.val[2] = z_value;
            got.done = calibration_done;
            check_reading(got);
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

@@ imu_sample_scale_offset_calibrate_unit.f @@
rtl/imu_cal_pkg.sv
rtl/imu_cal_lane.sv
rtl/imu_cal_ctrl.sv
rtl/imu_sample_scale_offset_calibrate_unit.sv
tb/sv/testbench.sv
